// ===== hdl/pqte_pkg.sv =====
`default_nettype none
package pqte_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int COEFFS       = 6;
    localparam int AXES         = 2;
    localparam int DUR_W        = 32;
    localparam int DIV_W        = 78;
    localparam int TAU_W        = 21;
    localparam int MAG_W        = 62;

    localparam logic [1:0] KIND_COEFF = 2'd0;
    localparam logic [1:0] KIND_DUR   = 2'd1;
    localparam logic [1:0] KIND_EVAL  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_WRITE     = 3'd1;
    localparam logic [2:0] ST_NOT_READY = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_BAD_DUR   = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         segment;
        logic [2:0]         coeff_index;
        logic               axis;
        logic signed [31:0] write_value;
        logic [31:0]        query_time;
        logic [2:0]         deriv_order;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] heading_value;
        logic signed [31:0] arc_value;
        logic [2:0]         status;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_CHECK,
        S_TAU_WAIT,
        S_AX_INIT,
        S_MUL_F,
        S_MUL_C,
        S_ACC,
        S_PW,
        S_DIV_START,
        S_DIV_WAIT,
        S_AX_DONE,
        S_OUT
    } t_state;

    // k!/(k-order)!
    function automatic logic [6:0] falling_fact(input logic [2:0] k, input logic [2:0] order);
        int f;
        f = 1;
        for (int i = 0; i < 5; i++) begin
            if (i < int'(order)) begin
                f = f * (int'(k) - i);
            end
        end
        return 7'(f);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/piecewise_quintic_trajectory_eval.sv =====
`default_nettype none
// Write words, unused kinds, not ready: accept, state S_OUT, then the registered result word.
// Evaluate over n segments, order d <= 5: the walk, the tau division, 6-d terms per axis and
// d scaling divisions per axis; above order 5 only the tau division, on a duration or range error
// only the walk. The walk reads one entry a cycle, the shared 78-step restoring divider dominates.
// One word in flight; the next word is taken while a result waits on the output.
// Synchronous active-low reset clears the sequencer, output valid and segment_count; stores kept.
module piecewise_quintic_trajectory_eval #(
    parameter int MAX_SEGMENTS = pqte_pkg::MAX_SEGMENTS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [6:0]           i_cfg_wdata,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire pqte_pkg::t_in_word   i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output pqte_pkg::t_out_word       o_out_word
);

    localparam int SEG_AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int CMP_W   = (CNT_W > 7) ? CNT_W : 7;
    localparam int SUM_W   = pqte_pkg::DUR_W + CNT_W;
    localparam int C_DEPTH = MAX_SEGMENTS * pqte_pkg::COEFFS * pqte_pkg::AXES;
    localparam int C_AW    = $clog2(C_DEPTH);
    localparam int TW      = pqte_pkg::TAU_W;
    localparam int MW      = pqte_pkg::MAG_W;
    localparam int DW      = pqte_pkg::DIV_W;
    localparam logic [TW-1:0] PW_ONE = TW'(1) << 20;
    localparam logic [MW-1:0] MAG_CAP = MW'(1) << 60;

    pqte_pkg::t_state    r_state, n_state;
    logic [6:0]          r_seg_count;
    logic [31:0]         r_t, n_t;
    logic [2:0]          r_order, n_order;
    logic [CNT_W-1:0]    r_issue, n_issue;
    logic                r_pend, n_pend;
    logic                r_bad, n_bad;
    logic [SUM_W-1:0]    r_cum, n_cum;
    logic [SUM_W-1:0]    r_start, n_start;
    logic [SEG_AW-1:0]   r_sel, n_sel;
    logic [31:0]         r_seldur, n_seldur;
    logic [TW-1:0]       r_tau, n_tau;
    logic                r_axis, n_axis;
    logic [2:0]          r_k, n_k;
    logic [TW-1:0]       r_pw, n_pw;
    logic [63:0]         r_prod, n_prod;
    logic signed [63:0]  r_acc, n_acc;
    logic [MW-1:0]       r_mag, n_mag;
    logic                r_neg, n_neg;
    logic [2:0]          r_m, n_m;
    logic [31:0]         r_hv, n_hv;
    logic [31:0]         r_av, n_av;
    logic [2:0]          r_status, n_status;
    logic                r_out_valid, n_out_valid;
    pqte_pkg::t_out_word r_out_word, n_out_word;

    logic              in_acc;
    logic [CNT_W-1:0]  seg_lim;
    logic              seg_ok;
    logic [CNT_W-1:0]  iss_m1;
    logic              dur_we;
    logic [SEG_AW-1:0] dur_addr;
    logic [31:0]       dur_rdata;
    logic              coef_we;
    logic [C_AW-1:0]   coef_addr;
    logic [31:0]       coef_rdata;
    logic              div_start;
    logic [DW-1:0]     div_dividend;
    logic              div_done;
    logic [DW-1:0]     div_quo;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [SUM_W-1:0]  local_t;
    logic [63:0]       acc_abs;
    logic [41:0]       shifted;
    logic [31:0]       sat_val;

    assign in_acc     = i_in_valid && (r_state == pqte_pkg::S_IDLE);
    assign o_in_stall = (r_state != pqte_pkg::S_IDLE);
    assign seg_ok     = int'(i_in_word.segment) < MAX_SEGMENTS;
    assign iss_m1     = r_issue - 1'b1;

    always_comb begin
        if (CMP_W'(r_seg_count) > CMP_W'(MAX_SEGMENTS)) begin
            seg_lim = CNT_W'(MAX_SEGMENTS);
        end else begin
            seg_lim = CNT_W'(r_seg_count);
        end
    end

    assign dur_we   = in_acc && (i_in_word.kind == pqte_pkg::KIND_DUR) && seg_ok
                      && !i_in_word.write_value[31] && (i_in_word.write_value != 32'sd0);
    assign dur_addr = in_acc ? SEG_AW'(i_in_word.segment) : r_issue[SEG_AW-1:0];

    assign coef_we   = in_acc && (i_in_word.kind == pqte_pkg::KIND_COEFF) && seg_ok
                       && (int'(i_in_word.coeff_index) < pqte_pkg::COEFFS);
    assign coef_addr = in_acc
        ? C_AW'({SEG_AW'(i_in_word.segment), i_in_word.axis}) * C_AW'(pqte_pkg::COEFFS)
          + C_AW'(i_in_word.coeff_index)
        : C_AW'({r_sel, r_axis}) * C_AW'(pqte_pkg::COEFFS) + C_AW'(r_k);

    pqte_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_dur_ram (
        .i_clk  (i_clk),
        .i_we   (dur_we),
        .i_addr (dur_addr),
        .i_wdata(i_in_word.write_value),
        .o_rdata(dur_rdata)
    );

    pqte_ram #(.WIDTH(32), .DEPTH(C_DEPTH)) u_coef_ram (
        .i_clk  (i_clk),
        .i_we   (coef_we),
        .i_addr (coef_addr),
        .i_wdata(i_in_word.write_value),
        .o_rdata(coef_rdata)
    );

    pqte_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dividend),
        .i_divisor (r_seldur),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    always_comb begin
        unique case (r_state)
            pqte_pkg::S_MUL_F: begin
                mul_a = {12'b0, r_pw};
                mul_b = {26'b0, pqte_pkg::falling_fact(r_k, r_order)};
            end
            pqte_pkg::S_MUL_C: begin
                mul_a = {coef_rdata[31], coef_rdata};
                mul_b = r_prod[32:0];
            end
            pqte_pkg::S_ACC: begin
                mul_a = {12'b0, r_pw};
                mul_b = {12'b0, r_tau};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        local_t = SUM_W'(r_t) - r_start;
        if (local_t > SUM_W'(r_seldur)) begin
            local_t = SUM_W'(r_seldur);
        end
    end

    assign acc_abs = r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
    assign shifted = r_mag[MW-1:20];

    always_comb begin
        if (r_neg) begin
            if (shifted > 42'h0_8000_0000) begin
                sat_val = 32'h8000_0000;
            end else begin
                sat_val = 32'(-shifted);
            end
        end else if (shifted > 42'h0_7FFF_FFFF) begin
            sat_val = 32'h7FFF_FFFF;
        end else begin
            sat_val = shifted[31:0];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_t          = r_t;
        n_order      = r_order;
        n_issue      = r_issue;
        n_pend       = r_pend;
        n_bad        = r_bad;
        n_cum        = r_cum;
        n_start      = r_start;
        n_sel        = r_sel;
        n_seldur     = r_seldur;
        n_tau        = r_tau;
        n_axis       = r_axis;
        n_k          = r_k;
        n_pw         = r_pw;
        n_prod       = r_prod;
        n_acc        = r_acc;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_m          = r_m;
        n_hv         = r_hv;
        n_av         = r_av;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        div_start    = 1'b0;
        div_dividend = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            pqte_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_t     = i_in_word.query_time;
                    n_order = i_in_word.deriv_order;
                    n_hv    = '0;
                    n_av    = '0;
                    n_issue = '0;
                    n_pend  = 1'b0;
                    n_bad   = 1'b0;
                    n_cum   = '0;
                    n_start = '0;
                    n_sel   = '0;
                    n_seldur = '0;
                    n_state = pqte_pkg::S_OUT;
                    priority if (i_in_word.kind == pqte_pkg::KIND_EVAL) begin
                        if (seg_lim == '0) begin
                            n_status = pqte_pkg::ST_NOT_READY;
                        end else begin
                            n_state = pqte_pkg::S_WALK;
                        end
                    end else if (i_in_word.kind == pqte_pkg::KIND_DUR
                                 && (i_in_word.write_value[31]
                                     || i_in_word.write_value == 32'sd0)) begin
                        n_status = pqte_pkg::ST_BAD_DUR;
                    end else begin
                        n_status = pqte_pkg::ST_WRITE;
                    end
                end
            end
            pqte_pkg::S_WALK: begin
                if (r_pend) begin
                    if (dur_rdata[31] || dur_rdata == 32'd0) begin
                        n_bad = 1'b1;
                    end
                    if (r_cum <= SUM_W'(r_t)) begin
                        n_sel    = iss_m1[SEG_AW-1:0];
                        n_start  = r_cum;
                        n_seldur = dur_rdata;
                    end
                    n_cum = r_cum + SUM_W'(dur_rdata);
                end
                if (r_issue < seg_lim) begin
                    n_issue = r_issue + 1'b1;
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = pqte_pkg::S_CHECK;
                    end
                end
            end
            pqte_pkg::S_CHECK: begin
                priority if (r_bad) begin
                    n_status = pqte_pkg::ST_BAD_DUR;
                    n_state  = pqte_pkg::S_OUT;
                end else if (SUM_W'(r_t) > r_cum) begin
                    n_status = pqte_pkg::ST_RANGE;
                    n_state  = pqte_pkg::S_OUT;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DW'({local_t[31:0], 20'b0});
                    n_state      = pqte_pkg::S_TAU_WAIT;
                end
            end
            pqte_pkg::S_TAU_WAIT: begin
                if (div_done) begin
                    n_tau  = div_quo[TW-1:0];
                    n_axis = 1'b0;
                    if (int'(r_order) >= pqte_pkg::COEFFS) begin
                        n_status = pqte_pkg::ST_OK;
                        n_state  = pqte_pkg::S_OUT;
                    end else begin
                        n_state = pqte_pkg::S_AX_INIT;
                    end
                end
            end
            pqte_pkg::S_AX_INIT: begin
                n_pw    = PW_ONE;
                n_acc   = '0;
                n_k     = r_order;
                n_state = pqte_pkg::S_MUL_F;
            end
            pqte_pkg::S_MUL_F: begin
                n_prod  = mul_p[63:0];
                n_state = pqte_pkg::S_MUL_C;
            end
            pqte_pkg::S_MUL_C: begin
                n_prod  = mul_p[63:0];
                n_state = pqte_pkg::S_ACC;
            end
            pqte_pkg::S_ACC: begin
                n_acc   = r_acc + signed'(r_prod);
                n_prod  = mul_p[63:0];
                n_state = pqte_pkg::S_PW;
            end
            pqte_pkg::S_PW: begin
                n_pw = r_prod[TW+19:20];
                if (int'(r_k) == pqte_pkg::COEFFS - 1) begin
                    n_mag = acc_abs[MW-1:0];
                    n_neg = r_acc[63];
                    n_m   = '0;
                    n_state = (r_order == 3'd0) ? pqte_pkg::S_AX_DONE : pqte_pkg::S_DIV_START;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = pqte_pkg::S_MUL_F;
                end
            end
            pqte_pkg::S_DIV_START: begin
                div_start    = 1'b1;
                div_dividend = DW'({r_mag, 16'b0});
                n_state      = pqte_pkg::S_DIV_WAIT;
            end
            pqte_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    n_mag = (div_quo > DW'(MAG_CAP)) ? MAG_CAP : div_quo[MW-1:0];
                    n_m   = r_m + 1'b1;
                    n_state = (r_m + 1'b1 == r_order) ? pqte_pkg::S_AX_DONE
                                                      : pqte_pkg::S_DIV_START;
                end
            end
            pqte_pkg::S_AX_DONE: begin
                if (!r_axis) begin
                    n_hv    = sat_val;
                    n_axis  = 1'b1;
                    n_state = pqte_pkg::S_AX_INIT;
                end else begin
                    n_av     = sat_val;
                    n_status = pqte_pkg::ST_OK;
                    n_state  = pqte_pkg::S_OUT;
                end
            end
            pqte_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_word.heading_value = r_hv;
                    n_out_word.arc_value     = r_av;
                    n_out_word.status        = r_status;
                    n_out_valid = 1'b1;
                    n_state     = pqte_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pqte_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pqte_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_seg_count <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_seg_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t        <= n_t;
        r_order    <= n_order;
        r_issue    <= n_issue;
        r_pend     <= n_pend;
        r_bad      <= n_bad;
        r_cum      <= n_cum;
        r_start    <= n_start;
        r_sel      <= n_sel;
        r_seldur   <= n_seldur;
        r_tau      <= n_tau;
        r_axis     <= n_axis;
        r_k        <= n_k;
        r_pw       <= n_pw;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_m        <= n_m;
        r_hv       <= n_hv;
        r_av       <= n_av;
        r_status   <= n_status;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == pqte_pkg::S_TAU_WAIT || r_state == pqte_pkg::S_DIV_WAIT))
        else $error("divider finished outside a wait state");

    a_pw_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pqte_pkg::S_MUL_F) |-> (r_pw <= PW_ONE))
        else $error("tau power above one");

    a_mag_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pqte_pkg::S_AX_DONE && r_order != 3'd0) |-> (r_mag <= MAG_CAP))
        else $error("scaled magnitude above cap");

    a_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.kind == pqte_pkg::KIND_EVAL && seg_lim == '0)
        |=> (r_state == pqte_pkg::S_OUT && r_status == pqte_pkg::ST_NOT_READY))
        else $error("evaluate without segments not refused");

endmodule
`default_nettype wire

// ===== hdl/pqte_ram.sv =====
`default_nettype none
module pqte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== hdl/pqte_div.sv =====
`default_nettype none
module pqte_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [pqte_pkg::DIV_W-1:0]      i_dividend,
    input  wire logic [pqte_pkg::DUR_W-1:0]      i_divisor,
    output logic                                 o_done,
    output logic      [pqte_pkg::DIV_W-1:0]      o_quotient
);

    localparam int DW    = pqte_pkg::DIV_W;
    localparam int NW    = pqte_pkg::DUR_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_rem;
    logic [NW-1:0]    r_den;
    logic [DW-1:0]    r_quo;

    logic [NW:0] rem_sh;
    logic [NW:0] diff;
    logic        ge;

    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[NW-1:0] : rem_sh[NW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire
